// File: sv/cpr_pkg.sv
// Package for the clock page replacement block: sizes, command and status codes,
// the queue entry type and the result type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cpr_pkg;
   localparam int FrameBits = 4;
   localparam int NumFrames = 1 << FrameBits;
   localparam int MaxPages = 256;
   localparam int PageBits = 8;
   localparam int CountBits = 9;

   typedef enum logic [1:0] {
      CMD_FAULT = 2'd0,
      CMD_MAP = 2'd1,
      CMD_UNMAP = 2'd2,
      CMD_ACCESS = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_UNMAPPED = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type cmd;
      logic [PageBits-1:0] page;
      logic is_write;
   } item_type;

   typedef struct packed {
      status_type status;
      logic [PageBits-1:0] new_page;
      logic [FrameBits-1:0] load_frame;
      logic do_load;
      logic do_writeback;
      logic [PageBits-1:0] writeback_page;
   } result_type;
endpackage
`default_nettype wire

// File: sv/cpr_fifo.sv
// Two-entry item queue between the front and back parts.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_fifo import cpr_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire item_type in_item,
   output logic out_valid,
   input wire logic out_ready,
   output item_type out_item
);
   item_type mem_ff [2];
   item_type mem_in [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      mem_in = mem_ff;
      if (push) mem_in[wp_ff] = in_item;
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> wp_ff == rp_ff) else $error("full queue pointers differ");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> wp_ff == rp_ff) else $error("empty queue pointers differ");
`endif
endmodule
`default_nettype wire

// File: sv/cpr_back.sv
// Back part: generic RAM, then the page replacement engine. Page table and unmap
// marks sit in RAM; frame owners, count and clock hand in registers. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(Depth)-1:0] addr,
   input wire logic [Width-1:0] wdata,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

module cpr_back import cpr_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [CountBits-1:0] csr_wdata,
   input wire logic in_valid,
   output logic in_ready,
   input wire item_type in_item,
   output logic out_valid,
   input wire logic out_ready,
   output result_type out_res
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_SWEEP, S_SWEEP_RD, S_LOAD, S_DONE
   } state_type;

   typedef struct packed {
      logic valid;
      logic dirty;
      logic refd;
      logic [FrameBits-1:0] frame;
   } pte_type;

   state_type st_ff, st_in;
   item_type it_ff, it_in;
   logic [FrameBits:0] k_ff, k_in;
   result_type res_ff, res_in;
   logic [CountBits-1:0] cnt_ff, cnt_in;
   logic [FrameBits-1:0] hand_ff, hand_in;
   logic ou_ff [NumFrames];
   logic ou_in [NumFrames];
   logic [PageBits-1:0] op_ff [NumFrames];
   logic [PageBits-1:0] op_in [NumFrames];
   logic [PageBits-1:0] clr_ff, clr_in;
   logic clr_pt_ff, clr_pt_in;

   logic pt_we;
   logic [PageBits-1:0] pt_addr;
   pte_type pt_wdata, pt_rd;
   logic um_we;
   logic [PageBits-1:0] um_addr;
   logic [0:0] um_wdata, um_rd;

   logic mapped, ou_h, victim_ok;
   logic [PageBits-1:0] op_h;
   logic [CountBits-1:0] sat;

   cpr_ram #(.Width($bits(pte_type)), .Depth(MaxPages)) u_pt (
      .clock, .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rd)
   );

   // a set mark means the page was unmapped since the last reload
   cpr_ram #(.Width(1), .Depth(MaxPages)) u_um (
      .clock, .we(um_we), .addr(um_addr), .wdata(um_wdata), .rdata(um_rd)
   );

   assign in_ready = (st_ff == S_IDLE) && !csr_we;
   assign out_valid = st_ff == S_DONE;
   assign out_res = res_ff;
   assign mapped = ({1'b0, it_ff.page} < cnt_ff) && !um_rd[0];
   assign ou_h = ou_ff[hand_ff];
   assign op_h = op_ff[hand_ff];
   assign victim_ok = k_ff[FrameBits] || !ou_h || !pt_rd.refd;
   assign sat = (csr_wdata > CountBits'(MaxPages)) ? CountBits'(MaxPages) : csr_wdata;

   always_comb begin
      st_in = st_ff;
      it_in = it_ff;
      k_in = k_ff;
      res_in = res_ff;
      cnt_in = cnt_ff;
      hand_in = hand_ff;
      ou_in = ou_ff;
      op_in = op_ff;
      clr_in = clr_ff;
      clr_pt_in = clr_pt_ff;
      pt_we = 1'b0;
      pt_addr = it_ff.page;
      pt_wdata = '0;
      um_we = 1'b0;
      um_addr = it_ff.page;
      um_wdata = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            pt_addr = clr_ff;
            pt_we = clr_pt_ff;
            um_addr = clr_ff;
            um_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PageBits'(MaxPages - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            pt_addr = in_item.page;
            um_addr = in_item.page;
            if (in_valid) begin
               it_in = in_item;
               k_in = '0;
               st_in = S_LOOK;
            end
         end
         S_LOOK: begin
            res_in = '0;
            st_in = S_DONE;
            unique case (it_ff.cmd)
               CMD_FAULT: begin
                  if (!mapped) res_in.status = ST_UNMAPPED;
                  else if (pt_rd.valid) res_in.load_frame = pt_rd.frame;
                  else begin
                     pt_addr = op_h;
                     st_in = S_SWEEP;
                  end
               end
               CMD_MAP: begin
                  if (cnt_ff >= CountBits'(MaxPages)) res_in.status = ST_FULL;
                  else begin
                     um_addr = cnt_ff[PageBits-1:0];
                     um_we = 1'b1;
                     res_in.new_page = cnt_ff[PageBits-1:0];
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               CMD_UNMAP: begin
                  if (mapped) begin
                     um_we = 1'b1;
                     um_wdata = 1'b1;
                     if (pt_rd.valid) begin
                        pt_we = 1'b1;
                        pt_wdata = pt_rd;
                        pt_wdata.valid = 1'b0;
                        pt_wdata.dirty = 1'b0;
                     end
                  end
               end
               CMD_ACCESS: begin
                  if (!mapped) res_in.status = ST_UNMAPPED;
                  else if (pt_rd.valid) begin
                     pt_we = 1'b1;
                     pt_wdata = pt_rd;
                     pt_wdata.refd = 1'b1;
                     pt_wdata.dirty = pt_rd.dirty | it_ff.is_write;
                  end
               end
            endcase
         end
         S_SWEEP: begin
            pt_addr = op_h;
            if (!victim_ok) begin
               pt_we = 1'b1;
               pt_wdata = pt_rd;
               pt_wdata.refd = 1'b0;
               hand_in = hand_ff + 1'b1;
               k_in = k_ff + 1'b1;
               st_in = S_SWEEP_RD;
            end else begin
               if (ou_h) begin
                  pt_we = 1'b1;
                  pt_wdata = pt_rd;
                  pt_wdata.valid = 1'b0;
                  pt_wdata.dirty = 1'b0;
                  if (pt_rd.dirty) begin
                     res_in.do_writeback = 1'b1;
                     res_in.writeback_page = op_h;
                  end
               end
               st_in = S_LOAD;
            end
         end
         S_SWEEP_RD: begin
            pt_addr = op_h;
            st_in = S_SWEEP;
         end
         S_LOAD: begin
            pt_we = 1'b1;
            pt_wdata.valid = 1'b1;
            pt_wdata.frame = hand_ff;
            ou_in[hand_ff] = 1'b1;
            op_in[hand_ff] = it_ff.page;
            res_in.load_frame = hand_ff;
            res_in.do_load = 1'b1;
            hand_in = hand_ff + 1'b1;
            st_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (csr_we) begin
         cnt_in = sat;
         clr_in = '0;
         clr_pt_in = 1'b0;
         st_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         it_ff <= '0;
         k_ff <= '0;
         res_ff <= '0;
         cnt_ff <= '0;
         hand_ff <= '0;
         clr_ff <= '0;
         clr_pt_ff <= 1'b1;
         for (int j = 0; j < NumFrames; j++) begin
            ou_ff[j] <= 1'b0;
            op_ff[j] <= '0;
         end
      end else begin
         st_ff <= st_in;
         it_ff <= it_in;
         k_ff <= k_in;
         res_ff <= res_in;
         cnt_ff <= cnt_in;
         hand_ff <= hand_in;
         clr_ff <= clr_in;
         clr_pt_ff <= clr_pt_in;
         ou_ff <= ou_in;
         op_ff <= op_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CountBits'(MaxPages)) else $error("page count above capacity");
   a_sweep: assert property (@(posedge clock) disable iff (reset)
      k_ff <= (FrameBits+1)'(NumFrames)) else $error("sweep overran");
   a_load: assert property (@(posedge clock) disable iff (reset)
      out_valid && res_ff.do_writeback |-> res_ff.do_load)
      else $error("write-back without load");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(res_ff)) else $error("result changed");
`endif
endmodule
`default_nettype wire

// File: sv/clock_page_replacement.sv
// Top level: item queue in front of the page replacement engine.
// Depends on cpr_pkg, cpr_fifo, cpr_back.
// channel | dir | fields (low bit up)
// req     | in  | tdata: cmd[1:0], page[9:2], is_write[10]
// rsp     | out | tdata: status, new_page, load_frame, do_load, do_writeback, wb page
// csr     | in  | initial_pages[8:0]
// A result is registered from the look-up state; a fault that loads a page goes through the
// sweep and load states, plus a re-read for each referenced frame the hand passes (at most 16).
// The next item starts the cycle after a result is taken.
// After reset the back part clears the page table and unmap marks of all 256 pages, after each
// csr write only the unmap marks, and takes no item meanwhile.
// A result waits in its register while the two-entry queue still takes items.
`timescale 1ns / 1ps
`default_nettype none
module clock_page_replacement import cpr_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [8:0] csr_wdata,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [15:0] req_tdata, // cmd, page, is_write, zero
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [23:0] rsp_tdata // status, new_page, load_frame, do_load, do_wb, wb_page
);
   item_type in_item, q_item;
   logic q_valid, q_ready;
   result_type res;

   assign in_item = item_type'({req_tdata[1:0], req_tdata[9:2], req_tdata[10]});

   cpr_fifo u_fifo (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   cpr_back u_back (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {res.writeback_page, res.do_writeback, res.do_load,
                       res.load_frame, res.new_page, res.status};
endmodule
`default_nettype wire

// File: sim/tb_clock_page_replacement.sv
// Testbench for clock_page_replacement: directed table then random traffic,
// every item checked against a local page-table predictor. Depends on cpr_pkg and the RTL.
`timescale 1ns / 1ps
module tb_clock_page_replacement;
   import cpr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [8:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   clock_page_replacement dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic pt_valid [MaxPages];
   logic pt_dirty [MaxPages];
   logic pt_ref [MaxPages];
   logic [FrameBits-1:0] pt_frame [MaxPages];
   logic own_used [NumFrames];
   logic [PageBits-1:0] own_page [NumFrames];
   logic map_bit [MaxPages];
   int unsigned alloc_count;
   logic [FrameBits-1:0] hand;

   result_type pending_results [$];
   int errors = 0;
   bit long_hold = 1'b0;
   bit stim_done = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic void reload_map(input logic [8:0] n);
      int unsigned lim;
      lim = (n > MaxPages) ? MaxPages : n;
      for (int i = 0; i < MaxPages; i++) map_bit[i] = (i < lim);
      alloc_count = lim;
   endfunction

   function automatic bit resident_ok(input int p);
      return p < alloc_count && map_bit[p];
   endfunction

   function automatic result_type predict_page_cmd(input item_type it);
      result_type r;
      int p;
      r = '0;
      r.status = ST_OK;
      p = it.page;
      case (it.cmd)
         CMD_FAULT: begin
            if (!resident_ok(p)) begin
               r.status = ST_UNMAPPED;
            end else if (pt_valid[p]) begin
               r.load_frame = pt_frame[p];
            end else begin
               for (int k = 0; k < NumFrames; k++) begin
                  if (!own_used[hand] || !pt_ref[own_page[hand]]) break;
                  pt_ref[own_page[hand]] = 1'b0;
                  hand = hand + 1'b1;
               end
               if (own_used[hand]) begin
                  if (pt_dirty[own_page[hand]]) begin
                     r.do_writeback = 1'b1;
                     r.writeback_page = own_page[hand];
                     pt_dirty[own_page[hand]] = 1'b0;
                  end
                  pt_valid[own_page[hand]] = 1'b0;
               end
               own_used[hand] = 1'b1;
               own_page[hand] = PageBits'(p);
               pt_valid[p] = 1'b1;
               pt_frame[p] = hand;
               pt_ref[p] = 1'b0;
               r.load_frame = hand;
               r.do_load = 1'b1;
               hand = hand + 1'b1;
            end
         end
         CMD_MAP: begin
            if (alloc_count >= MaxPages) begin
               r.status = ST_FULL;
            end else begin
               r.new_page = PageBits'(alloc_count);
               map_bit[alloc_count] = 1'b1;
               alloc_count++;
            end
         end
         CMD_UNMAP: begin
            if (resident_ok(p)) begin
               map_bit[p] = 1'b0;
               if (pt_valid[p]) begin
                  pt_dirty[p] = 1'b0;
                  pt_valid[p] = 1'b0;
               end
            end
         end
         default: begin
            if (!resident_ok(p)) begin
               r.status = ST_UNMAPPED;
            end else if (pt_valid[p]) begin
               pt_ref[p] = 1'b1;
               if (it.is_write) pt_dirty[p] = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   // response checking
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[1:0]);
         got.new_page = rsp_tdata[9:2];
         got.load_frame = rsp_tdata[13:10];
         got.do_load = rsp_tdata[14];
         got.do_writeback = rsp_tdata[15];
         got.writeback_page = rsp_tdata[23:16];
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status) report_mismatch("status", got.status, want.status);
            if (got.new_page != want.new_page)
               report_mismatch("new_page", got.new_page, want.new_page);
            if (got.load_frame != want.load_frame)
               report_mismatch("load_frame", got.load_frame, want.load_frame);
            if (got.do_load != want.do_load) report_mismatch("do_load", got.do_load, want.do_load);
            if (got.do_writeback != want.do_writeback)
               report_mismatch("do_writeback", got.do_writeback, want.do_writeback);
            if (got.writeback_page != want.writeback_page)
               report_mismatch("writeback_page", got.writeback_page, want.writeback_page);
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         mode = $urandom_range(0, 9);
         if (stim_done || mode < 3) rsp_tready <= 1'b1;
         else if (mode < 6) rsp_tready <= ($urandom_range(0, 3) != 0);
         else rsp_tready <= 1'($urandom_range(0, 1));
      end
   end

   task automatic send_item(input item_type it, input bit typed_in, input result_type typed);
      result_type want;
      req_tdata <= {5'b0, it.is_write, it.page, it.cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      want = predict_page_cmd(it);
      if (typed_in && want != typed) report_mismatch("directed table", typed, want);
      pending_results.push_back(want);
   endtask

   task automatic write_csr(input logic [8:0] v);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (25) @(posedge clock);
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      reload_map(v);
   endtask

   function automatic item_type mk(input cmd_type c, input int p, input bit w);
      item_type it;
      it.cmd = c;
      it.page = PageBits'(p);
      it.is_write = w;
      return it;
   endfunction

   function automatic result_type st(input status_type s, input int np);
      result_type r;
      r = '0;
      r.status = s;
      r.new_page = PageBits'(np);
      return r;
   endfunction

   typedef struct {
      item_type it;
      bit typed_in;
      result_type typed;
   } row_type;

   row_type dir_rows [$];

   initial begin
      item_type it;
      int burst, sel, pool;
      result_type zr;
      zr = '0;
      for (int i = 0; i < MaxPages; i++) begin
         pt_valid[i] = 0; pt_dirty[i] = 0; pt_ref[i] = 0; pt_frame[i] = 0;
      end
      for (int i = 0; i < NumFrames; i++) begin
         own_used[i] = 0; own_page[i] = 0;
      end
      hand = '0;
      reload_map(9'd0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, from reset with nothing mapped
      dir_rows = '{
         '{mk(CMD_FAULT, 0, 0), 1, st(ST_UNMAPPED, 0)},
         '{mk(CMD_ACCESS, 255, 1), 1, st(ST_UNMAPPED, 0)},
         '{mk(CMD_UNMAP, 255, 1), 1, st(ST_OK, 0)},
         '{mk(CMD_MAP, 0, 0), 1, st(ST_OK, 0)},
         '{mk(CMD_MAP, 170, 1), 1, st(ST_OK, 1)},
         '{mk(CMD_FAULT, 0, 0), 0, zr},
         '{mk(CMD_FAULT, 0, 0), 0, zr},
         '{mk(CMD_ACCESS, 0, 1), 0, zr},
         '{mk(CMD_ACCESS, 1, 0), 0, zr},
         '{mk(CMD_FAULT, 1, 0), 0, zr},
         '{mk(CMD_ACCESS, 1, 1), 0, zr},
         '{mk(CMD_UNMAP, 1, 0), 0, zr},
         '{mk(CMD_FAULT, 1, 0), 1, st(ST_UNMAPPED, 0)},
         '{mk(CMD_MAP, 85, 0), 1, st(ST_OK, 2)}
      };
      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed_in, dir_rows[i].typed);

      // full page space: map answers full
      write_csr(9'd256);
      send_item(mk(CMD_MAP, 0, 0), 1, st(ST_FULL, 0));
      send_item(mk(CMD_FAULT, 255, 1), 0, zr);
      write_csr(9'd511);
      send_item(mk(CMD_MAP, 255, 1), 1, st(ST_FULL, 0));
      send_item(mk(CMD_ACCESS, 255, 1), 0, zr);

      // random phases over several sizes of page space
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_csr(9'd20);
            1: write_csr(9'd40);
            2: write_csr(9'd0);
            3: write_csr(9'd255);
            4: write_csr(9'($urandom_range(10, 60)));
            default: write_csr(9'd24);
         endcase
         if (ph == 1) long_hold = 1'b1;
         for (int n = 0; n < 285; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < 285; b++, n++) begin
               pool = (alloc_count < 8) ? 8 : alloc_count + 2;
               if (pool > 256) pool = 256;
               sel = $urandom_range(0, 99);
               if (sel < 40) it = mk(CMD_FAULT, $urandom_range(0, pool - 1), $urandom_range(0, 1));
               else if (sel < 75)
                  it = mk(CMD_ACCESS, $urandom_range(0, pool - 1), $urandom_range(0, 1));
               else if (sel < 85) it = mk(CMD_MAP, $urandom_range(0, 255), $urandom_range(0, 1));
               else if (sel < 95)
                  it = mk(CMD_UNMAP, $urandom_range(0, pool - 1), $urandom_range(0, 1));
               else it = mk(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                            $urandom_range(0, 1));
               send_item(it, 0, zr);
            end
            if ($urandom_range(0, 2) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("clock_page_replacement verification clean");
      else $display("clock_page_replacement verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("clock_page_replacement verification failed");
      $finish;
   end
endmodule

// File: clock_page_replacement.f
sv/cpr_pkg.sv
sv/cpr_fifo.sv
sv/cpr_back.sv
sv/clock_page_replacement.sv
sim/tb_clock_page_replacement.sv
